/* hw/rtl/stl_pkg.sv */
// Shared types and token kind codes for the stencil language tokenizer.
package stl_pkg;

    // Token kinds
    localparam logic [4:0] K_END     = 5'd0;
    localparam logic [4:0] K_SYM0    = 5'd1;
    localparam logic [4:0] K_IDENT   = 5'd14;
    localparam logic [4:0] K_INT     = 5'd15;
    localparam logic [4:0] K_FLOAT   = 5'd16;
    localparam logic [4:0] K_KW0     = 5'd17;
    localparam logic [4:0] K_UNKNOWN = 5'd28;
    localparam logic [4:0] K_NOEXP   = 5'd29;

    // One result item
    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start_offset;
        logic [15:0] token_length;
        logic [62:0] int_value;
        logic        last_of_run;
    } stl_result_t;

    // Result queue status towards the top level
    typedef struct packed {
        logic has_data;
        logic room_two;
    } stl_fifo_stat_t;

endpackage

/* hw/rtl/stl_lexer.sv */
// Lexer state and single-character step logic, giving up to two results.
module stl_lexer #(
    parameter int POS_WIDTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         ch,
    input  logic               end_mark,
    output stl_pkg::stl_result_t res_a,
    output stl_pkg::stl_result_t res_b,
    output logic [1:0]         res_count
);
    import stl_pkg::*;

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_IDENT   = 3'd1;
    localparam logic [2:0] MODE_NUM     = 3'd2;
    localparam logic [2:0] MODE_EXP0    = 3'd3;
    localparam logic [2:0] MODE_EXPSIGN = 3'd4;
    localparam logic [2:0] MODE_EXPDIG  = 3'd5;
    localparam logic [2:0] MODE_ERROR   = 3'd6;

    localparam int NUM_KW = 11;
    localparam int KW_CHARS = 7;
    localparam int OFF_W = (POS_WIDTH > 16) ? POS_WIDTH : 16;
    localparam logic [62:0] INT_MAX63 = {63{1'b1}};

    // Keyword text, first character in the top byte, zero padded
    localparam logic [55:0] KW_TEXT [NUM_KW] = '{
        {"double", 8'h00}, {"field", 16'h0000}, {"float", 16'h0000},
        {"grid", 24'h000000}, {"in", 40'h0}, {"inout", 16'h0000},
        {"is", 40'h0}, {"let", 32'h0}, {"out", 32'h0},
        {"param", 16'h0000}, {"program"}
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd6, 3'd5, 3'd5, 3'd4, 3'd2, 3'd5, 3'd2, 3'd3, 3'd3, 3'd5, 3'd7
    };

    // Symbol decoder: 0 when the byte is no symbol
    function automatic logic [4:0] sym_kind(input logic [7:0] c);
        logic [4:0] k;
        unique case (c)
            "+":     k = K_SYM0;
            "-":     k = K_SYM0 + 5'd1;
            "*":     k = K_SYM0 + 5'd2;
            "/":     k = K_SYM0 + 5'd3;
            "$":     k = K_SYM0 + 5'd4;
            "@":     k = K_SYM0 + 5'd5;
            "=":     k = K_SYM0 + 5'd6;
            "(":     k = K_SYM0 + 5'd7;
            ")":     k = K_SYM0 + 5'd8;
            "[":     k = K_SYM0 + 5'd9;
            "]":     k = K_SYM0 + 5'd10;
            ",":     k = K_SYM0 + 5'd11;
            ":":     k = K_SYM0 + 5'd12;
            default: k = 5'd0;
        endcase
        return k;
    endfunction

    logic [2:0]           mode_reg,  mode_next;
    logic [POS_WIDTH-1:0] pos_reg,   pos_next;
    logic [POS_WIDTH-1:0] start_reg, start_next;
    logic [15:0]          len_reg,   len_next;
    logic [62:0]          acc_reg,   acc_next;
    logic                 frac_reg,  frac_next;
    logic [7:0]           kw_reg [KW_CHARS];

    logic       kw_wr_en;
    logic [2:0] kw_wr_idx;

    // Character classes
    logic       c_alpha, c_digit, c_ws, c_word;
    logic [4:0] c_sym;
    logic [3:0] c_val;
    assign c_alpha = ((ch >= "A") && (ch <= "Z")) || ((ch >= "a") && (ch <= "z"));
    assign c_digit = (ch >= "0") && (ch <= "9");
    assign c_ws    = (ch == 8'h09) || (ch == 8'h20) || (ch == 8'h0D) || (ch == 8'h0A);
    assign c_word  = c_alpha || c_digit || (ch == "_");
    assign c_sym   = sym_kind(ch);
    assign c_val   = ch[3:0];

    // Offsets carried on the low 16 bits of the position
    logic [OFF_W-1:0] pos_wide, start_wide;
    assign pos_wide   = OFF_W'(pos_reg);
    assign start_wide = OFF_W'(start_reg);

    // Saturating length increment
    logic [15:0] len_grow;
    assign len_grow = (len_reg == 16'hFFFF) ? len_reg : len_reg + 16'd1;

    // Accumulator times ten plus digit, saturating at the signed 64-bit maximum
    logic [66:0] acc_x10;
    logic [62:0] acc_step;
    assign acc_x10  = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + 67'(c_val);
    assign acc_step = (acc_x10 > {4'b0000, INT_MAX63}) ? INT_MAX63 : acc_x10[62:0];

    // Keyword match over the stored leading characters
    logic [4:0] ident_kind;
    always_comb
    begin
        logic hit;
        ident_kind = K_IDENT;
        for (int k = 0; k < NUM_KW; k++)
        begin
            hit = (len_reg == 16'(KW_LEN[k]));
            for (int j = 0; j < KW_CHARS; j++)
            begin
                if ((j < int'(KW_LEN[k])) && (kw_reg[j] != KW_TEXT[k][55 - 8*j -: 8]))
                begin
                    hit = 1'b0;
                end
            end
            if (hit && (ident_kind == K_IDENT))
            begin
                ident_kind = 5'(K_KW0 + 5'(k));
            end
        end
    end

    // Next state and results for one character or end marker
    stl_result_t ra, rb;
    logic        ra_valid, rb_valid;
    logic        start_apply;

    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        acc_next    = acc_reg;
        frac_next   = frac_reg;
        kw_wr_en    = 1'b0;
        kw_wr_idx   = 3'd0;
        ra_valid    = 1'b0;
        rb_valid    = 1'b0;
        start_apply = 1'b0;

        // Finished token so far
        ra.kind         = K_IDENT;
        ra.start_offset = start_wide[15:0];
        ra.token_length = len_reg;
        ra.int_value    = '0;
        ra.last_of_run  = 1'b0;

        // Token from the start of a new one, or the end token
        rb.kind         = (c_sym != 5'd0) ? c_sym : K_UNKNOWN;
        rb.start_offset = pos_wide[15:0];
        rb.token_length = 16'd1;
        rb.int_value    = '0;
        rb.last_of_run  = 1'b1;

        if (end_mark)
        begin
            unique case (mode_reg) inside
                MODE_IDENT:
                begin
                    ra_valid = 1'b1;
                    ra.kind  = ident_kind;
                end
                MODE_NUM, MODE_EXPDIG:
                begin
                    ra_valid     = 1'b1;
                    ra.kind      = frac_reg ? K_FLOAT : K_INT;
                    ra.int_value = frac_reg ? 63'd0 : acc_reg;
                end
                MODE_EXP0, MODE_EXPSIGN:
                begin
                    ra_valid = 1'b1;
                    ra.kind  = K_NOEXP;
                end
                default:
                begin
                end
            endcase
            rb_valid        = 1'b1;
            rb.kind         = K_END;
            rb.token_length = 16'd0;
            // back to the reset state
            mode_next  = MODE_IDLE;
            pos_next   = '0;
            start_next = '0;
            len_next   = '0;
            acc_next   = '0;
            frac_next  = 1'b0;
        end
        else
        begin
            pos_next = pos_reg + POS_WIDTH'(1);
            unique case (mode_reg) inside
                MODE_IDLE:
                begin
                    start_apply = 1'b1;
                end
                MODE_IDENT:
                begin
                    if (c_word)
                    begin
                        kw_wr_en  = (len_reg < 16'd7);
                        kw_wr_idx = len_reg[2:0];
                        len_next  = len_grow;
                    end
                    else
                    begin
                        ra_valid    = 1'b1;
                        ra.kind     = ident_kind;
                        mode_next   = MODE_IDLE;
                        start_apply = 1'b1;
                    end
                end
                MODE_NUM:
                begin
                    if (c_digit)
                    begin
                        if (!frac_reg)
                        begin
                            acc_next = acc_step;
                        end
                        len_next = len_grow;
                    end
                    else if (ch == ".")
                    begin
                        frac_next = 1'b1;
                        len_next  = len_grow;
                    end
                    else if ((ch == "e") || (ch == "E"))
                    begin
                        frac_next = 1'b1;
                        len_next  = len_grow;
                        mode_next = MODE_EXP0;
                    end
                    else
                    begin
                        ra_valid     = 1'b1;
                        ra.kind      = frac_reg ? K_FLOAT : K_INT;
                        ra.int_value = frac_reg ? 63'd0 : acc_reg;
                        mode_next    = MODE_IDLE;
                        start_apply  = 1'b1;
                    end
                end
                MODE_EXP0, MODE_EXPSIGN:
                begin
                    if (c_digit)
                    begin
                        len_next  = len_grow;
                        mode_next = MODE_EXPDIG;
                    end
                    else if ((ch == "-") && (mode_reg == MODE_EXP0))
                    begin
                        len_next  = len_grow;
                        mode_next = MODE_EXPSIGN;
                    end
                    else
                    begin
                        ra_valid  = 1'b1;
                        ra.kind   = K_NOEXP;
                        mode_next = MODE_ERROR;
                    end
                end
                MODE_EXPDIG:
                begin
                    if (c_digit)
                    begin
                        len_next = len_grow;
                    end
                    else
                    begin
                        ra_valid     = 1'b1;
                        ra.kind      = frac_reg ? K_FLOAT : K_INT;
                        ra.int_value = frac_reg ? 63'd0 : acc_reg;
                        mode_next    = MODE_IDLE;
                        start_apply  = 1'b1;
                    end
                end
                default:
                begin
                    // error: swallow everything until the end marker
                end
            endcase

            // Start of a new token at this character
            if (start_apply && !c_ws)
            begin
                if (c_sym != 5'd0)
                begin
                    rb_valid = 1'b1;
                end
                else
                begin
                    start_next = pos_reg;
                    len_next   = 16'd1;
                    if (c_alpha)
                    begin
                        mode_next = MODE_IDENT;
                        kw_wr_en  = 1'b1;
                        kw_wr_idx = 3'd0;
                    end
                    else if (c_digit)
                    begin
                        mode_next = MODE_NUM;
                        acc_next  = 63'(c_val);
                        frac_next = 1'b0;
                    end
                    else
                    begin
                        rb_valid  = 1'b1;
                        mode_next = MODE_ERROR;
                    end
                end
            end
        end
    end

    // Order the results and mark the final one
    always_comb
    begin
        res_b = rb;
        if (ra_valid)
        begin
            res_a             = ra;
            res_a.last_of_run = !rb_valid;
            res_count         = rb_valid ? 2'd2 : 2'd1;
        end
        else
        begin
            res_a     = rb;
            res_count = rb_valid ? 2'd1 : 2'd0;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            acc_reg   <= '0;
            frac_reg  <= 1'b0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            acc_reg   <= acc_next;
            frac_reg  <= frac_next;
        end
    end

    // Leading identifier characters, written before they are read
    always_ff @(posedge clk)
    begin
        if (step && kw_wr_en)
        begin
            kw_reg[kw_wr_idx] <= ch;
        end
    end

endmodule

/* hw/rtl/stl_out_fifo.sv */
// Three-entry result queue taking up to two results per cycle.
module stl_out_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [1:0]             push_count,
    input  stl_pkg::stl_result_t   push_a,
    input  stl_pkg::stl_result_t   push_b,
    input  logic                   pop,
    output stl_pkg::stl_result_t   head,
    output stl_pkg::stl_fifo_stat_t stat
);
    import stl_pkg::*;

    localparam int DEPTH = 3;

    function automatic logic [1:0] ptr_inc(input logic [1:0] p);
        return (p == 2'(DEPTH - 1)) ? 2'd0 : p + 2'd1;
    endfunction

    stl_result_t slot_reg [DEPTH];
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  count_reg,  count_next;
    logic [1:0]  wr_ptr_b;

    assign wr_ptr_b = ptr_inc(wr_ptr_reg);
    assign head     = slot_reg[rd_ptr_reg];

    // Room for two results once this cycle's transfer has left
    assign stat.has_data = (count_reg != 2'd0);
    assign stat.room_two = (count_reg <= 2'd1) || ((count_reg == 2'd2) && pop);

    // Pointer and fill count update
    always_comb
    begin
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        case (push_count)
            2'd1:    wr_ptr_next = wr_ptr_b;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_b);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        count_next = count_reg + push_count - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 2'd0;
            wr_ptr_reg <= 2'd0;
            count_reg  <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            slot_reg[wr_ptr_reg] <= push_a;
        end
        if (push_count == 2'd2)
        begin
            slot_reg[wr_ptr_b] <= push_b;
        end
    end

endmodule

/* hw/rtl/stencil_language_tokenizer.sv */
// Top level of the stencil language tokenizer: input register, lexer step, result queue.
//
// Takes one source byte, or an end-of-buffer marker, per transfer and gives tokens
// (kind, start offset, length, integer value) with last_of_run on the final result of
// each input. An input is accepted in every cycle in which the input register is empty
// or its held input steps the lexer, which needs room for two results in the queue. It
// is captured in the input register, passes the combinational lexer step and lands in
// a three-entry result queue, from which results leave one per cycle while out_ready is
// high; an input that closes one token and emits another (or the end marker after an
// open token) yields two results. Identifier characters beyond the seventh are not
// stored and only count towards the length; there is no clearing pass after reset.
module stencil_language_tokenizer #(
    parameter int POS_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    input  logic        end_mark,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  kind,
    output logic [15:0] start_offset,
    output logic [15:0] token_length,
    output logic [62:0] int_value,
    output logic        last_of_run
);
    import stl_pkg::*;

    logic       in_valid_reg;
    logic [7:0] ch_reg;
    logic       end_reg;
    logic       step;
    logic       pop;

    stl_result_t    res_a, res_b, head;
    logic [1:0]     res_count;
    stl_fifo_stat_t fifo_stat;

    // Step the lexer when an input is held and the queue can take two results
    assign step     = in_valid_reg && fifo_stat.room_two;
    assign in_ready = !in_valid_reg || step;
    assign pop      = fifo_stat.has_data && out_ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ch_reg  <= ch;
            end_reg <= end_mark;
        end
    end

    stl_lexer #(
        .POS_WIDTH (POS_WIDTH)
    ) u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .ch        (ch_reg),
        .end_mark  (end_reg),
        .res_a     (res_a),
        .res_b     (res_b),
        .res_count (res_count)
    );

    stl_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (step ? res_count : 2'd0),
        .push_a     (res_a),
        .push_b     (res_b),
        .pop        (pop),
        .head       (head),
        .stat       (fifo_stat)
    );

    assign out_valid    = fifo_stat.has_data;
    assign kind         = head.kind;
    assign start_offset = head.start_offset;
    assign token_length = head.token_length;
    assign int_value    = head.int_value;
    assign last_of_run  = head.last_of_run;

    // An end marker always closes its run with the end token
    a_end_token: assert property (@(posedge clk) disable iff (!rst_n)
        step && end_reg |-> (res_count == 2'd2 && res_b.kind == K_END && res_b.last_of_run)
                         || (res_count == 2'd1 && res_a.kind == K_END && res_a.last_of_run))
        else $error("end marker did not finish with an end token");

    // With two results only the second is marked final
    a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
        res_count == 2'd2 |-> !res_a.last_of_run && res_b.last_of_run)
        else $error("wrong final marking on a pair of results");

    // The end token leaving the block is always the final result of its run
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == K_END |-> last_of_run)
        else $error("end token transferred without last_of_run");

    // A stepped input leaves a result queue that is never empty next cycle when it gave results
    a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_count != 2'd0 |=> out_valid)
        else $error("results were lost in the queue");

endmodule
